FILE: sv/sua_pkg.sv
package sua_pkg;

	// Widths of the stream fields.
	localparam int unsigned OP_W      = 4;
	localparam int unsigned FIELD_W   = 64;
	localparam int unsigned S_TDATA_W = 72;
	localparam int unsigned M_TDATA_W = 64;

	// Default datapath width.
	localparam int unsigned DATA_WIDTH_DEF = 64;

	// Bit position of the write-back flag in the input tdata.
	localparam int unsigned WB_BIT = 64;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_AND  = 4'd0;
	localparam logic [OP_W-1:0] OP_OR   = 4'd1;
	localparam logic [OP_W-1:0] OP_XOR  = 4'd2;
	localparam logic [OP_W-1:0] OP_NOT  = 4'd3;
	localparam logic [OP_W-1:0] OP_LOAD = 4'd4;
	localparam logic [OP_W-1:0] OP_ADD  = 4'd5;
	localparam logic [OP_W-1:0] OP_SUB  = 4'd6;
	localparam logic [OP_W-1:0] OP_MUL  = 4'd7;
	localparam logic [OP_W-1:0] OP_DIV  = 4'd8;
	localparam logic [OP_W-1:0] OP_INC  = 4'd9;
	localparam logic [OP_W-1:0] OP_DEC  = 4'd10;

	// Completion status handed from the engine to the top level.
	typedef struct packed {
		logic valid;
		logic write_back;
	} sua_status_t;

endpackage

FILE: sv/sua_addsub.sv
module sua_addsub import sua_pkg::*; #(
	parameter int unsigned W = DATA_WIDTH_DEF
) (
	input  logic [W:0]   x,
	input  logic [W:0]   y,
	input  logic         sub,
	output logic [W+1:0] s
);

	// Bit W+1 is the borrow of a subtraction; bit W is the carry of a W-bit add.
	always_comb begin
		if (sub) begin
			s = {1'b0, x} - {1'b0, y};
		end else begin
			s = {1'b0, x} + {1'b0, y};
		end
	end

endmodule

FILE: sv/sua_engine.sv
module sua_engine import sua_pkg::*; #(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [OP_W-1:0]       op_in,
	input  logic [DATA_WIDTH-1:0] operand_in,
	input  logic                  wb_in,
	input  logic [DATA_WIDTH-1:0] acc,
	input  logic                  take,
	output logic                  ready,
	output sua_status_t           status,
	output logic [DATA_WIDTH-1:0] result
);

	localparam int unsigned W  = DATA_WIDTH;
	localparam int unsigned CW = $clog2(DATA_WIDTH);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_ITER  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic [W-1:0]  MAX      = '1;
	localparam logic [CW-1:0] CNT_LAST = CW'(DATA_WIDTH - 1);

	logic [1:0]      state_q, state_d;
	logic [OP_W-1:0] op_q;
	logic            wb_q;
	logic [W-1:0]    b_q;
	logic [W-1:0]    p_q, p_d;
	logic [W-1:0]    q_q, q_d;
	logic            ovf_q, ovf_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [W-1:0]    res_q, res_d;

	logic [W:0]      ux, uy;
	logic            usub;
	logic [W+1:0]    us;

	sua_addsub #(.W(W)) u_addsub (
		.x   (ux),
		.y   (uy),
		.sub (usub),
		.s   (us)
	);

	// Operand steering for the shared adder.
	always_comb begin
		ux   = {1'b0, acc};
		uy   = {1'b0, b_q};
		usub = 1'b0;
		if (state_q == ST_ITER) begin
			if (op_q == OP_MUL) begin
				// Double the partial product, then add the accumulator if the bit is set.
				ux = {1'b0, p_q[W-2:0], 1'b0};
				uy = q_q[W-1] ? {1'b0, acc} : '0;
			end else begin
				// Shift in the next dividend bit and trial-subtract the divisor.
				ux   = {p_q, q_q[W-1]};
				uy   = {1'b0, b_q};
				usub = 1'b1;
			end
		end else begin
			unique case (op_q)
				OP_SUB: usub = 1'b1;
				OP_INC: uy = (W+1)'(1);
				OP_DEC: begin
					uy   = (W+1)'(1);
					usub = 1'b1;
				end
				default: usub = 1'b0;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		p_d     = p_q;
		q_d     = q_q;
		ovf_d   = ovf_q;
		cnt_d   = cnt_q;
		res_d   = res_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				state_d = ST_DONE;
				unique case (op_q)
					OP_AND:  res_d = acc & b_q;
					OP_OR:   res_d = acc | b_q;
					OP_XOR:  res_d = acc ^ b_q;
					OP_NOT:  res_d = ~acc;
					OP_LOAD: res_d = b_q;
					OP_ADD:  res_d = us[W] ? MAX : us[W-1:0];
					OP_SUB:  res_d = us[W+1] ? '0 : us[W-1:0];
					OP_INC:  res_d = us[W] ? MAX : us[W-1:0];
					OP_DEC:  res_d = us[W+1] ? '0 : us[W-1:0];
					OP_MUL: begin
						p_d     = '0;
						q_d     = b_q;
						ovf_d   = 1'b0;
						cnt_d   = CNT_LAST;
						state_d = ST_ITER;
					end
					OP_DIV: begin
						if (b_q == '0) begin
							res_d = (acc != '0) ? MAX : '0;
						end else begin
							p_d     = '0;
							q_d     = acc;
							cnt_d   = CNT_LAST;
							state_d = ST_ITER;
						end
					end
					default: res_d = acc;
				endcase
			end
			ST_ITER: begin
				if (op_q == OP_MUL) begin
					// Any carry out of the product register means the true product exceeds MAX.
					p_d   = us[W-1:0];
					q_d   = {q_q[W-2:0], 1'b0};
					ovf_d = ovf_q | p_q[W-1] | us[W];
					res_d = ovf_d ? MAX : p_d;
				end else begin
					if (us[W+1]) begin
						p_d = {p_q[W-2:0], q_q[W-1]};
					end else begin
						p_d = us[W-1:0];
					end
					q_d   = {q_q[W-2:0], ~us[W+1]};
					res_d = q_d;
				end
				if (cnt_q == '0) begin
					state_d = ST_DONE;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_DONE: begin
				if (take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q <= op_in;
			wb_q <= wb_in;
			b_q  <= operand_in;
		end
		p_q   <= p_d;
		q_q   <= q_d;
		ovf_q <= ovf_d;
		cnt_q <= cnt_d;
		res_q <= res_d;
	end

	assign ready             = (state_q == ST_IDLE);
	assign status.valid      = (state_q == ST_DONE);
	assign status.write_back = wb_q;
	assign result            = res_q;

endmodule

FILE: sv/saturating_unsigned_accumulator_alu_unit.sv
// Logic, load, add, sub, inc, dec and divide by zero finish in the engine's start
// state; multiply and divide run its one-bit-per-cycle loop. A new input beat is
// accepted only after the last result has moved into the output register.
// Reset: arst_n clears the accumulator to zero, the sequencer to idle and the
// output register to empty.
module saturating_unsigned_accumulator_alu_unit import sua_pkg::*; #(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// Bits from the lowest: operand [63:0], write_back [64], zero fill [71:65].
	input  logic [S_TDATA_W-1:0] s_tdata,
	// Bits from the lowest: op [3:0].
	input  logic [OP_W-1:0]      s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// Bits from the lowest: result [63:0].
	output logic [M_TDATA_W-1:0] m_tdata
);

	logic [DATA_WIDTH-1:0] acc_q;
	logic                  m_tvalid_q;
	logic [M_TDATA_W-1:0]  m_tdata_q;

	logic                  eng_ready;
	sua_status_t           eng_status;
	logic [DATA_WIDTH-1:0] eng_result;
	logic                  take;

	// The engine accepts a beat only when idle. It runs one item at a time, with the
	// shared adder doing the add, subtract, increment and decrement directly and
	// stepping the shift-add multiply and the restoring divide one bit per cycle.
	sua_engine #(.DATA_WIDTH(DATA_WIDTH)) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (s_tvalid),
		.op_in      (s_tuser),
		.operand_in (s_tdata[DATA_WIDTH-1:0]),
		.wb_in      (s_tdata[WB_BIT]),
		.acc        (acc_q),
		.take       (take),
		.ready      (eng_ready),
		.status     (eng_status),
		.result     (eng_result)
	);

	assign s_tready = eng_ready;

	// A finished result moves into the output register when it is empty or being
	// drained in this same cycle, which frees the engine for the next beat.
	assign take = eng_status.valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			acc_q      <= '0;
		end else begin
			if (take) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			// The accumulator follows the result only when write-back was requested.
			if (take && eng_status.write_back) begin
				acc_q <= eng_result;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			m_tdata_q <= M_TDATA_W'(eng_result);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: sim/saturating_unsigned_accumulator_alu_unit_tb.sv
`timescale 1ns / 1ps

module saturating_unsigned_accumulator_alu_unit_tb;
	import sua_pkg::*;

	typedef logic [OP_W-1:0]    op_t;
	typedef logic [FIELD_W-1:0] word_t;

	// Operation codes past OP_DEC are not decoded; the block passes the accumulator through.
	localparam op_t   OP_UNDEF_LO = OP_DEC + 1'b1;
	localparam op_t   OP_UNDEF_HI = '1;
	localparam word_t WORD_MAX    = '1;
	localparam int    MAX_REPORTS = 10;
	localparam int    BURST_MAX   = 14;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// Bits from the lowest: operand [63:0], write_back [64], zero fill [71:65].
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	// Bits from the lowest: op [3:0].
	op_t                  s_tuser  = OP_AND;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// Bits from the lowest: result [63:0].
	logic [M_TDATA_W-1:0] m_tdata;

	// Accumulator as the testbench sees it, updated when an input beat is accepted.
	word_t acc_model = '0;
	// Results that accepted beats still owe, oldest first.
	word_t results_due[$];

	int fail_count   = 0;
	int stall_left   = 0;
	bit src_idle_en  = 1'b1;
	bit sink_idle_en = 1'b1;

	saturating_unsigned_accumulator_alu_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// What the block must emit for one operation on accumulator value a and operand b.
	// Sums are formed one bit wider and products twice as wide so that overflow is seen directly.
	function automatic word_t saturated_result(input op_t op, input word_t a, input word_t b);
		logic [FIELD_W:0]     sum;
		logic [2*FIELD_W-1:0] product;
		sum     = {1'b0, a} + {1'b0, b};
		product = {{FIELD_W{1'b0}}, a} * {{FIELD_W{1'b0}}, b};
		case (op)
			OP_AND:  return a & b;
			OP_OR:   return a | b;
			OP_XOR:  return a ^ b;
			OP_NOT:  return ~a;
			OP_LOAD: return b;
			OP_ADD:  return sum[FIELD_W] ? WORD_MAX : sum[FIELD_W-1:0];
			OP_SUB:  return (b > a) ? '0 : a - b;
			OP_MUL:  return (product[2*FIELD_W-1:FIELD_W] != '0) ? WORD_MAX
				: product[FIELD_W-1:0];
			// Division by zero saturates a nonzero dividend and leaves zero at zero.
			OP_DIV:  return (b == '0) ? ((a != '0) ? WORD_MAX : '0) : a / b;
			OP_INC:  return (a == WORD_MAX) ? a : a + 1'b1;
			OP_DEC:  return (a == '0) ? a : a - 1'b1;
			default: return a;
		endcase
	endfunction

	task automatic note_failure(input string what, input word_t want, input word_t got);
		fail_count++;
		if (fail_count <= MAX_REPORTS) begin
			$display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
		end
	endtask

	// Offers one beat, optionally after a random gap, and returns once it has been taken.
	// The valid line is left high so that a following beat goes out with no bubble; any
	// code that lets time pass without sending lowers it first.
	task automatic send_item(input op_t op, input word_t operand, input logic write_back);
		logic [S_TDATA_W-1:0] beat;
		word_t                outcome;
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, BURST_MAX)) @(posedge clk);
		end
		beat                  = '0;
		beat[FIELD_W-1:0]     = operand;
		beat[WB_BIT]          = write_back;
		s_tvalid <= 1'b1;
		s_tdata  <= beat;
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		outcome = saturated_result(op, acc_model, operand);
		if (write_back) begin
			acc_model = outcome;
		end
		results_due.push_back(outcome);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
	endtask

	// Random beat. The operand is drawn from several classes so that carries, borrows,
	// product overflow and exact quotients all occur, and write-back is mostly set so the
	// accumulator wanders through many values instead of sticking at zero.
	task automatic send_random_item();
		op_t   op;
		word_t operand;
		if ($urandom_range(0, 99) < 90) begin
			op = op_t'($urandom_range(OP_AND, OP_DEC));
		end else begin
			op = op_t'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
		end
		case ($urandom_range(0, 9))
			0:       operand = '0;
			1:       operand = WORD_MAX;
			2:       operand = word_t'($urandom_range(0, 16));
			3:       operand = word_t'($urandom);
			4:       operand = acc_model + word_t'($urandom_range(0, 4)) - word_t'(2);
			5:       operand = word_t'(1) << $urandom_range(0, FIELD_W - 1);
			default: operand = {$urandom, $urandom};
		endcase
		send_item(op, operand, $urandom_range(0, 3) != 0);
	endtask

	task automatic test_logic_ops();
		send_item(OP_LOAD, WORD_MAX, 1'b1);
		send_item(OP_AND, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0);
		send_item(OP_XOR, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
		// The operand of a NOT is ignored, so give it every bit set.
		send_item(OP_NOT, WORD_MAX, 1'b1);
	endtask

	task automatic test_add_sub_saturation();
		send_item(OP_LOAD, WORD_MAX - 1'b1, 1'b1);
		send_item(OP_ADD, word_t'(1), 1'b0);
		send_item(OP_ADD, word_t'(2), 1'b1);
		send_item(OP_LOAD, word_t'(5), 1'b1);
		send_item(OP_SUB, word_t'(6), 1'b0);
		send_item(OP_SUB, word_t'(5), 1'b0);
	endtask

	task automatic test_mul_div();
		send_item(OP_LOAD, word_t'(1) << 32, 1'b1);
		// The largest product that still fits, then the smallest one that does not.
		send_item(OP_MUL, 64'h0000_0000_FFFF_FFFF, 1'b0);
		send_item(OP_MUL, word_t'(1) << 32, 1'b0);
		send_item(OP_DIV, '0, 1'b0);
		send_item(OP_DIV, word_t'(3), 1'b0);
		send_item(OP_LOAD, '0, 1'b1);
		send_item(OP_DIV, '0, 1'b0);
	endtask

	task automatic test_inc_dec();
		send_item(OP_DEC, WORD_MAX, 1'b0);
		send_item(OP_INC, '0, 1'b1);
		send_item(OP_NOT, '0, 1'b1);
		send_item(OP_INC, '0, 1'b1);
		send_item(OP_INC, WORD_MAX, 1'b0);
	endtask

	task automatic test_undefined_ops();
		send_item(OP_UNDEF_LO, {$urandom, $urandom}, 1'b1);
		send_item(OP_UNDEF_HI, {$urandom, $urandom}, 1'b0);
	endtask

	// Long random run; the idle switches on each side are redrawn every few dozen beats so
	// that stretches with gaps, with stalls, with both and with neither all occur.
	task automatic test_random_mix();
		for (int i = 0; i < 900; i++) begin
			if (i % 60 == 0) begin
				src_idle_en  = ($urandom_range(0, 3) != 0);
				sink_idle_en = ($urandom_range(0, 3) != 0);
			end
			send_random_item();
		end
	endtask

	// The sender holds off until every owed result has come back, several times over.
	task automatic test_drain_pause();
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
		for (int group = 0; group < 6; group++) begin
			for (int i = 0; i < 25; i++) begin
				send_random_item();
			end
			wait_drained();
		end
	endtask

	// Final stretch at full rate on both sides.
	task automatic test_back_to_back();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		for (int i = 0; i < 250; i++) begin
			send_random_item();
		end
	endtask

	// Result side: each accepted beat is compared with the oldest owed result, and the
	// ready line is then redrawn for the next cycle, in stall bursts when enabled.
	always @(posedge clk) begin : result_port
		word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				note_failure("result beat with nothing owed", '0, m_tdata);
			end else begin
				want = results_due.pop_front();
				if (m_tdata !== want) begin
					note_failure("result mismatch", want, m_tdata);
				end
			end
		end
		if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, BURST_MAX - 1);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_logic_ops();
		test_add_sub_saturation();
		test_mul_div();
		test_inc_dec();
		test_undefined_ops();
		test_random_mix();
		test_drain_pause();
		test_back_to_back();
		wait_drained();
		// Any stray beat after the last owed result is caught by the result port here.
		repeat (DATA_WIDTH_DEF + 8) @(posedge clk);
		if (fail_count == 0 && results_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog, set far beyond the slowest legal run of this stimulus.
	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
